>>> design/hmm_allele_log_likelihood_assert.svh
// Assertion macros for the allele log-likelihood block.
// Used by the port checker; needs nothing else.
`ifndef HMM_ALLELE_LOG_LIKELIHOOD_ASSERT_SVH
`define HMM_ALLELE_LOG_LIKELIHOOD_ASSERT_SVH

// Checked only while the block is out of reset.
`define HAL_ASSERT_RUN(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("hal check failed");

// Checked at every edge, reset included.
`define HAL_ASSERT_ALL(lbl, ck, prop) \
  lbl: assert property (@(posedge ck) prop) else $error("hal check failed");

`endif

>>> design/hal_pkg.sv
// Shared types and constants of the allele log-likelihood block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package hal_pkg;
  localparam int SYMBOL_COUNT = 4;
  localparam int FRAC_BITS    = 16;
  localparam int LOG_W        = 24;
  localparam int TOT_W        = 48;
  localparam int SUM_W        = 32;
  localparam int SUM_FRAC     = 24;
  localparam int X_W          = LOG_W + 1;
  localparam int Z_W          = X_W + 18;
  localparam int EXP_SHIFT    = FRAC_BITS + 16;
  localparam int INTERP_SHIFT = EXP_SHIFT - 4;
  localparam int LOG2E_Q16    = 94548;
  localparam int LN2_Q16      = 45426;
  localparam int LN_SHIFT     = 32 - FRAC_BITS;
  localparam int LOG_MIN      = -8388608;
  localparam int LOG_MAX      = 8388607;

  typedef logic [17:0] tab_t;
  localparam tab_t POW2_TAB [17] = '{
    18'd65536, 18'd68438, 18'd71468, 18'd74632, 18'd77936, 18'd81386,
    18'd84990, 18'd88752, 18'd92682, 18'd96785, 18'd101070, 18'd105545,
    18'd110218, 18'd115098, 18'd120194, 18'd125515, 18'd131072
  };

  typedef struct packed {
    logic [SUM_W-1:0] term;
    logic             close;
    logic             fin;
  } q_entry_t;

  typedef enum logic [5:0] {
    ST_RUN   = 6'b000001,
    ST_NORM  = 6'b000010,
    ST_LOG   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_ROUND = 6'b010000,
    ST_TOT   = 6'b100000
  } back_state_t;
endpackage
`default_nettype wire

>>> design/hal_ifs.sv
// Channel interfaces of the allele log-likelihood block.
// Depends on nothing but the field widths written here.
`timescale 1ns / 1ps
`default_nettype none
interface hal_in_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] emission_aa;
  logic signed [23:0] emission_het;
  logic signed [23:0] emission_bb;
  logic signed [23:0] emission_nocall;
  logic        [1:0]  observed_symbol;
  logic signed [23:0] pred_log;
  logic               last_state;
  logic               last_of_run;
  modport source (output valid, emission_aa, emission_het, emission_bb, emission_nocall,
                  observed_symbol, pred_log, last_state, last_of_run, input ready);
  modport sink (input valid, emission_aa, emission_het, emission_bb, emission_nocall,
                observed_symbol, pred_log, last_state, last_of_run, output ready);
endinterface

interface hal_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample_log_sum;
  logic signed [47:0] total_log_likelihood;
  logic               is_final;
  modport source (output valid, sample_log_sum, total_log_likelihood, is_final,
                  input ready);
  modport sink (input valid, sample_log_sum, total_log_likelihood, is_final,
                output ready);
endinterface
`default_nettype wire

>>> design/hal_front.sv
// Front end: accepts terms, selects the emission and runs the exp pipeline.
// Depends on hal_pkg and hal_in_if.
`timescale 1ns / 1ps
`default_nettype none
module hal_front import hal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  hal_in_if.sink   in_ch,
  output logic     push_valid,
  output q_entry_t push_data,
  input  logic     push_ready
);
  logic adv;
  logic v1_r, v2_r, v3_r;
  logic signed [X_W-1:0] x_r, x_nxt;
  logic signed [Z_W-1:0] z_r;
  logic en1_r, en2_r, en3_r, cl1_r, cl2_r, cl3_r, fn1_r, fn2_r, fn3_r;
  logic signed [23:0] emis;
  logic [3:0] idx;
  logic [INTERP_SHIFT-1:0] rem;
  logic [12:0] diff;
  logic [INTERP_SHIFT+12:0] ip;
  logic [17:0] v_nxt, v_r;
  logic signed [Z_W-EXP_SHIFT-1:0] k;
  logic signed [11:0] sh_nxt, sh_r;
  logic [11:0] neg_sh;
  logic [SUM_W-1:0] term;

  assign adv         = !v3_r || push_ready;
  assign in_ch.ready = adv;
  assign push_valid  = v3_r;

  always_comb begin
    case (in_ch.observed_symbol)
      2'd0:    emis = in_ch.emission_aa;
      2'd1:    emis = in_ch.emission_het;
      2'd2:    emis = in_ch.emission_bb;
      default: emis = in_ch.emission_nocall;
    endcase
    x_nxt = X_W'(emis) + X_W'(in_ch.pred_log);
  end

  // Split the base-2 exponent into an integer part and a table fraction.
  always_comb begin
    k      = z_r[Z_W-1:EXP_SHIFT];
    sh_nxt = 12'(k) + 12'(SUM_FRAC - 16);
    idx    = z_r[EXP_SHIFT-1 -: 4];
    rem    = z_r[INTERP_SHIFT-1:0];
    diff   = 13'(POW2_TAB[5'(idx) + 5'd1] - POW2_TAB[5'(idx)]);
    ip     = diff * rem;
    v_nxt  = POW2_TAB[5'(idx)] + 18'(ip >> INTERP_SHIFT);
  end

  always_comb begin
    neg_sh = -sh_r;
    if (!en3_r)           term = '0;
    else if (sh_r >= 16)  term = '1;
    else if (sh_r >= 0)   term = 32'({15'd0, v_r} << sh_r[3:0]);
    else if (sh_r <= -32) term = '0;
    else                  term = {14'd0, v_r} >> neg_sh[4:0];
  end

  assign push_data = '{term: term, close: cl3_r, fin: fn3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r   <= x_nxt;
      en1_r <= ({1'b0, in_ch.observed_symbol} < 3'(SYMBOL_COUNT));
      cl1_r <= in_ch.last_state || in_ch.last_of_run;
      fn1_r <= in_ch.last_of_run;
      z_r   <= x_r * $signed({1'b0, 17'(LOG2E_Q16)});
      en2_r <= en1_r;
      cl2_r <= cl1_r;
      fn2_r <= fn1_r;
      v_r   <= v_nxt;
      sh_r  <= sh_nxt;
      en3_r <= en2_r;
      cl3_r <= cl2_r;
      fn3_r <= fn2_r;
    end
  end
endmodule
`default_nettype wire

>>> design/hal_fifo.sv
// Four-entry queue between the front end and the back end.
// Depends on hal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module hal_fifo import hal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  input  q_entry_t push_data,
  output logic     push_ready,
  output logic     pop_valid,
  output q_entry_t pop_data,
  input  logic     pop
);
  q_entry_t   mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 3'd4);
  assign pop_valid  = (cnt_r != 3'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 2'd1;
      if (do_pop)  rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(do_push) - 3'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_data;
  end
endmodule
`default_nettype wire

>>> design/hal_back.sv
// Back end: sums exp terms, takes the log per sample and keeps the total.
// Depends on hal_pkg and hal_out_if.
`timescale 1ns / 1ps
`default_nettype none
module hal_back import hal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_entry_t  q_data,
  output logic      q_pop,
  hal_out_if.source out_ch
);
  back_state_t state_r, state_nxt;
  logic [SUM_W-1:0] sum_r, n_r;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_new;
  logic [4:0]  p_r;
  logic [30:0] m_r;
  logic [15:0] frac_r;
  logic [3:0]  bit_r;
  logic [61:0] sq;
  logic [31:0] sq_s;
  logic signed [6:0]  pm;
  logic signed [22:0] l_val;
  logic signed [40:0] prod_r, rnd;
  logic signed [LOG_W-1:0] ln_r;
  logic fin_r;
  logic signed [TOT_W-1:0] total_r;
  logic signed [TOT_W:0]   tot_sum;
  logic signed [TOT_W-1:0] tot_sat;
  logic out_free, out_load;
  logic out_valid_r, out_fin_r;
  logic signed [LOG_W-1:0] out_ln_r;
  logic signed [TOT_W-1:0] out_tot_r;

  assign q_pop    = (state_r == ST_RUN) && q_valid;
  assign out_free = !out_valid_r || out_ch.ready;
  assign out_load = (state_r == ST_TOT) && out_free;

  assign out_ch.valid                = out_valid_r;
  assign out_ch.sample_log_sum       = out_ln_r;
  assign out_ch.total_log_likelihood = out_tot_r;
  assign out_ch.is_final             = out_fin_r;

  always_comb begin
    sum_add = {1'b0, sum_r} + {1'b0, q_data.term};
    sum_new = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    sq      = m_r * m_r;
    sq_s    = sq[61:30];
    pm      = $signed({2'b00, p_r}) - 7'sd24;
    l_val   = {pm, frac_r};
    rnd     = (prod_r + 41'sd32768) >>> LN_SHIFT;
    tot_sum = {total_r[TOT_W-1], total_r} + {{(TOT_W-LOG_W+1){ln_r[LOG_W-1]}}, ln_r};
    if (tot_sum[TOT_W] != tot_sum[TOT_W-1])
      tot_sat = tot_sum[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}} : {1'b0, {(TOT_W-1){1'b1}}};
    else
      tot_sat = tot_sum[TOT_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (q_valid && q_data.close) state_nxt = (sum_new == '0) ? ST_TOT : ST_NORM;
      end
      ST_NORM:  if (n_r[31]) state_nxt = ST_LOG;
      ST_LOG:   if (bit_r == 4'd0) state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_TOT;
      ST_TOT:   if (out_free) state_nxt = ST_RUN;
      default:  state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      sum_r       <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop) sum_r <= q_data.close ? '0 : sum_new;
      if (out_load) begin
        out_valid_r <= 1'b1;
        total_r     <= fin_r ? '0 : tot_sat;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_RUN: begin
        n_r   <= sum_new;
        p_r   <= 5'd31;
        fin_r <= q_data.fin;
        ln_r  <= LOG_W'(LOG_MIN);
      end
      ST_NORM: begin
        // Coarse byte steps first, then single bits, until bit 31 is set.
        if (n_r[31:24] == 8'd0) begin
          n_r <= n_r << 8;
          p_r <= p_r - 5'd8;
        end else if (!n_r[31]) begin
          n_r <= n_r << 1;
          p_r <= p_r - 5'd1;
        end else begin
          m_r    <= n_r[31:1];
          frac_r <= '0;
          bit_r  <= 4'd15;
        end
      end
      ST_LOG: begin
        if (sq_s[31]) begin
          m_r    <= sq_s[31:1];
          frac_r <= frac_r | (16'd1 << bit_r);
        end else begin
          m_r <= sq_s[30:0];
        end
        bit_r <= bit_r - 4'd1;
      end
      ST_SCALE: prod_r <= l_val * $signed({1'b0, 17'(LN2_Q16)});
      ST_ROUND: begin
        if (rnd < 41'(LOG_MIN))      ln_r <= LOG_W'(LOG_MIN);
        else if (rnd > 41'(LOG_MAX)) ln_r <= LOG_W'(LOG_MAX);
        else                         ln_r <= rnd[LOG_W-1:0];
      end
      default: ;
    endcase
    if (out_load) begin
      out_ln_r  <= ln_r;
      out_tot_r <= tot_sat;
      out_fin_r <= fin_r;
    end
  end
endmodule
`default_nettype wire

>>> design/hmm_allele_log_likelihood.sv
// Allele log-likelihood accumulator over HMM state terms.
// Input channel in_ch: one beat per hidden-state term of a sample, carrying the
// four emission log-probabilities, the observed symbol, the predictive log and
// the last_state / last_of_run marks.
// Output channel out_ch: one beat per closing term (last_state or last_of_run)
// with the sample's log sum, the running total and is_final.
// Throughput: the three-stage exp pipeline and the four-entry queue let terms
// enter every cycle unless a full queue stalls the front end. A closing term
// holds the back end for up to 11 normalization steps, 16 squaring steps of
// the shared log multiplier, then scale, round and total; a closing term whose
// sum is zero goes straight to the total.
// Reset (synchronous, rst_n low) clears the sum, the total and the queue.
// If the receiver stalls, the result beat holds, the queue fills and in_ch.ready
// drops; nothing is lost. The total clears after the is_final beat is formed.
// Depends on hal_pkg, hal_ifs, hal_front, hal_fifo and hal_back.
`timescale 1ns / 1ps
`default_nettype none
module hmm_allele_log_likelihood import hal_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  hal_in_if.sink    in_ch,
  hal_out_if.source out_ch
);
  logic     push_valid, push_ready, pop_valid, pop;
  q_entry_t push_data, pop_data;

  hal_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .push_valid(push_valid), .push_data(push_data), .push_ready(push_ready)
  );

  hal_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push_valid(push_valid), .push_data(push_data), .push_ready(push_ready),
    .pop_valid(pop_valid), .pop_data(pop_data), .pop(pop)
  );

  hal_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(pop_valid), .q_data(pop_data), .q_pop(pop), .out_ch(out_ch)
  );
endmodule
`default_nettype wire

>>> design/hal_checker.sv
// Port checker for the allele log-likelihood block, bound to its top level.
// Depends on hmm_allele_log_likelihood_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "hmm_allele_log_likelihood_assert.svh"
module hal_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] sample_log_sum,
  input logic signed [47:0] total_log_likelihood,
  input logic               is_final
);
  `HAL_ASSERT_ALL(a_reset_clears, clk, !rst_n |=> !out_valid)
  `HAL_ASSERT_RUN(a_hold_stalled, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(sample_log_sum) && $stable(total_log_likelihood) && $stable(is_final))
  `HAL_ASSERT_RUN(a_log_range, clk, rst_n, out_valid |-> sample_log_sum <= 24'sd524287)
endmodule

bind hmm_allele_log_likelihood hal_port_checker u_hal_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .sample_log_sum(out_ch.sample_log_sum),
  .total_log_likelihood(out_ch.total_log_likelihood),
  .is_final(out_ch.is_final)
);
`default_nettype wire

>>> test/hal_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the allele log-likelihood block: watches both channels,
// predicts each sample's log sum and running total, and counts mismatches.
// Depends on hal_pkg and hal_ifs.
module hal_checker import hal_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  hal_in_if     in_ch,
  hal_out_if    out_ch,
  output int    fail_count,
  output int    pending_count
);

  typedef struct {
    logic signed [23:0] log_sum;
    logic signed [47:0] total;
    logic               fin;
  } sample_result_t;

  localparam logic [31:0] SUM_SAT = 32'hFFFF_FFFF;
  localparam longint TOTAL_MAX = 64'sd140737488355327;
  localparam longint TOTAL_MIN = -64'sd140737488355328;

  sample_result_t expected_q[$];
  logic [31:0]    exp_sum;
  longint         running_total;

  function automatic longint floor_div(longint a, int s);
    return a >>> s;
  endfunction

  // Fixed-point exp of a Q16 log value, giving a Q8.24 term.
  function automatic logic [31:0] exp_term(longint x);
    longint z, k, r, rem, v, sh;
    int idx;
    z = x * LOG2E_Q16;
    k = floor_div(z, EXP_SHIFT);
    r = z - (k <<< EXP_SHIFT);
    idx = int'((r >> INTERP_SHIFT) & 15);
    rem = r & ((64'sd1 <<< INTERP_SHIFT) - 1);
    v = longint'(POW2_TAB[idx]) +
        ((longint'(POW2_TAB[idx+1] - POW2_TAB[idx]) * rem) >>> INTERP_SHIFT);
    sh = k + (SUM_FRAC - 16);
    if (sh >= 16) return SUM_SAT;
    if (sh >= 0) return 32'(v << sh);
    if (sh <= -32) return 32'd0;
    return 32'(v >> (-sh));
  endfunction

  // Natural log of a Q8.24 sum, in Q8.16, saturated to the output range.
  function automatic longint ln_of_sum(logic [31:0] s);
    int p;
    logic [63:0] m;
    longint frac, l, ln;
    if (s == 0) return LOG_MIN;
    p = 31;
    frac = 0;
    while (!s[p]) p--;
    m = (p <= 30) ? (64'(s) << (30 - p)) : (64'(s) >> 1);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac |= (64'sd1 << b);
      end
    end
    l = longint'(p - SUM_FRAC) * 65536 + frac;
    ln = floor_div(l * LN2_Q16 + (64'sd1 <<< (31 - FRAC_BITS)), LN_SHIFT);
    if (ln < LOG_MIN) ln = LOG_MIN;
    if (ln > LOG_MAX) ln = LOG_MAX;
    return ln;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    logic [1:0]     sym;
    longint         x, ln, tot;
    logic [31:0]    t, ns;
    sample_result_t r;
    if (!rst_n) begin
      exp_sum = 0;
      running_total = 0;
      expected_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sym = in_ch.observed_symbol;
        if (int'(sym) < SYMBOL_COUNT) begin
          case (sym)
            2'd0: x = in_ch.emission_aa;
            2'd1: x = in_ch.emission_het;
            2'd2: x = in_ch.emission_bb;
            default: x = in_ch.emission_nocall;
          endcase
          x = x + longint'(in_ch.pred_log);
          t = exp_term(x);
          ns = exp_sum + t;
          exp_sum = (ns < exp_sum) ? SUM_SAT : ns;
        end
        if (in_ch.last_state || in_ch.last_of_run) begin
          ln = ln_of_sum(exp_sum);
          tot = running_total + ln;
          if (tot > TOTAL_MAX) tot = TOTAL_MAX;
          if (tot < TOTAL_MIN) tot = TOTAL_MIN;
          running_total = in_ch.last_of_run ? 0 : tot;
          exp_sum = 0;
          r.log_sum = 24'(ln);
          r.total = 48'(tot);
          r.fin = in_ch.last_of_run;
          expected_q.push_back(r);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          r = expected_q.pop_front();
          if (out_ch.sample_log_sum !== r.log_sum)
            report("sample_log_sum", out_ch.sample_log_sum, r.log_sum);
          if (out_ch.total_log_likelihood !== r.total)
            report("total_log_likelihood", out_ch.total_log_likelihood, r.total);
          if (out_ch.is_final !== r.fin)
            report("is_final", out_ch.is_final, r.fin);
        end
      end
    end
  end

endmodule

>>> test/tb_hmm_allele_log_likelihood.sv
`timescale 1ns / 1ps
// Top of the allele log-likelihood testbench: clock, reset, stimulus and verdict.
// Depends on hal_pkg, hal_ifs, hal_checker and the block itself.
module tb_hmm_allele_log_likelihood;
  import hal_pkg::*;

  localparam int NUM_RANDOM = 1900;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  bit   stim_done;
  bit   hold_off;

  hal_in_if  in_ch();
  hal_out_if out_ch();

  hmm_allele_log_likelihood DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  hal_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Log values mostly near zero so that sums stay in range, sometimes extreme.
  function automatic logic [23:0] rand_log();
    case ($urandom_range(0, 9))
      0: return 24'h800000;
      1: return 24'h000000;
      2: return 24'($urandom);
      3: return -24'($urandom_range(0, 2000000));
      default: return -24'($urandom_range(0, 400000));
    endcase
  endfunction

  // The valid line stays high between back-to-back beats and drops only for a gap.
  task automatic send_term(logic [23:0] aa, logic [23:0] het, logic [23:0] bb,
                           logic [23:0] nc, logic [1:0] sym, logic [23:0] pred,
                           logic last, logic fin);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if ($urandom_range(0, 1)) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.emission_aa <= aa;
    in_ch.emission_het <= het;
    in_ch.emission_bb <= bb;
    in_ch.emission_nocall <= nc;
    in_ch.observed_symbol <= sym;
    in_ch.pred_log <= pred;
    in_ch.last_state <= last;
    in_ch.last_of_run <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_term(logic last, logic fin);
    send_term(rand_log(), rand_log(), rand_log(), rand_log(), 2'($urandom),
              rand_log(), last, fin);
  endtask

  // Receiver: random stalls, plus one long hold-off while items keep coming.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("hmm_allele_log_likelihood verification failed");
      $finish;
    end
  end

  initial begin
    int states;
    int n;
    stim_done = 1'b0;
    hold_off = 1'b0;
    idle_cycles = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.emission_aa = '0;
    in_ch.emission_het = '0;
    in_ch.emission_bb = '0;
    in_ch.emission_nocall = '0;
    in_ch.observed_symbol = '0;
    in_ch.pred_log = '0;
    in_ch.last_state = 1'b0;
    in_ch.last_of_run = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each symbol, extremes, zero sum, saturation, final closes.
    for (int s = 0; s < 4; s++)
      send_term(24'h000000, 24'hFF0000, 24'hFE0000, 24'hFD0000, 2'(s), 24'h000000,
                1'b1, 1'b0);
    send_term(24'h800000, 24'h800000, 24'h800000, 24'h800000, 2'd0, 24'h800000,
              1'b1, 1'b0);
    send_term(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 2'd2, 24'h7FFFFF,
              1'b0, 1'b0);
    send_term(24'h7FFFFF, 24'h000000, 24'h000000, 24'h000000, 2'd0, 24'h7FFFFF,
              1'b1, 1'b0);
    send_term(24'h000000, 24'h000000, 24'h000000, 24'h000000, 2'd3, 24'h000000,
              1'b0, 1'b0);
    send_term(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 2'd1, 24'hFFFFFF,
              1'b0, 1'b1);
    send_term(24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA, 2'd1, 24'h555555,
              1'b1, 1'b1);
    send_term(24'hF00000, 24'hF00000, 24'hF00000, 24'hF00000, 2'd3, 24'h000000,
              1'b0, 1'b1);

    // Random: samples of a few states, runs of several samples.
    n = 0;
    while (n < NUM_RANDOM) begin
      if (n > 600 && n < 700) hold_off = 1'b1;
      states = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80)
                                             : $urandom_range(1, 8);
      for (int i = 0; i < states; i++) begin
        send_random_term(i == states - 1 ? 1'b1 : ($urandom_range(0, 40) == 0),
                         i == states - 1 && $urandom_range(0, 7) == 0);
        n++;
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("hmm_allele_log_likelihood verification clean");
    else
      $display("hmm_allele_log_likelihood verification failed");
    $finish;
  end

endmodule
